// ===== hw/rtl/msup_pkg.sv =====
// shared types, constants and register map of the motor safety supervisor
package msup_pkg;

  // time base width, all timestamps and elapsed times use it
  localparam int TimeWidth = 32;

  // configuration port geometry
  localparam int CfgAddrWidth = 4;
  localparam int CfgDataWidth = 32;

  // register indexes
  localparam logic [1:0] RegStallDriveLimit = 2'd0;
  localparam logic [1:0] RegStallTimeMs     = 2'd1;
  localparam logic [1:0] RegLinkTimeoutMs   = 2'd2;
  localparam logic [1:0] RegForceLimit      = 2'd3;

  // register reset values
  localparam logic [14:0] StallDriveLimitRst = 15'd800;
  localparam logic [15:0] StallTimeMsRst     = 16'd500;
  localparam logic [15:0] LinkTimeoutMsRst   = 16'd100;
  localparam logic [11:0] ForceLimitRst      = 12'd3500;

  // encoder motion band, a delta strictly inside +/- this counts as no motion
  localparam logic signed [15:0] MotionBand = 16'sd5;

  typedef logic [TimeWidth-1:0] time_t;

  typedef enum logic [1:0] {
    CmdCheck = 2'd0,
    CmdFrame = 2'd1,
    CmdRearm = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ErrNone  = 2'd0,
    ErrLink  = 2'd1,
    ErrStall = 2'd2,
    ErrForce = 2'd3
  } err_t;

  typedef struct packed {
    logic [14:0] stall_drive_limit;
    logic [15:0] stall_time_ms;
    logic [15:0] link_timeout_ms;
    logic [11:0] force_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         cmd;
    time_t              now_ms;
    logic signed [15:0] drive_level;
    logic signed [15:0] encoder_count;
    logic [11:0]        force_raw;
  } item_t;

  typedef struct packed {
    logic [1:0] fault_code;
    logic       estop_active;
    logic       stop_motor;
  } result_t;

endpackage

// ===== hw/rtl/motor_safety_supervisor_top.sv =====
// top level of the motor safety supervisor with input and result registers
//
// Usage: each item on the input channel (in_valid/in_ready) carries a command
// (check, frame received, re-arm), the current millisecond tick and the drive,
// encoder and force samples. Every item gives exactly one result on the output
// channel (out_valid/out_ready): fault code, stop-latched flag and a
// stop_motor flag on the item that newly latches the stop.
// An accepted transfer lands in the input register, is evaluated against the
// supervisor state and its result is captured in the result register. The
// block takes one item per cycle while the receiver does not stall; the only
// feedback path is the supervisor state, updated in the same cycle as the
// result register.
// A receiver stall holds the result register; the input register still takes
// one more item, after which in_ready drops until the result drains.
// Reset (rst, synchronous) empties both registers, clears all stall, link and
// latch state and loads the limit registers with their defaults. The limits
// sit behind an apb-style port with pready tied high; write them only while
// no items are in flight.
module motor_safety_supervisor_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [msup_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [msup_pkg::CfgDataWidth-1:0] pwdata,
  output logic [msup_pkg::CfgDataWidth-1:0] prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        cmd,
  input  logic [31:0]                       now_ms,
  input  logic signed [15:0]                drive_level,
  input  logic signed [15:0]                encoder_count,
  input  logic [11:0]                       force_raw,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        fault_code,
  output logic                              estop_active,
  output logic                              stop_motor
);
  import msup_pkg::*;

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    fire;
  result_t result;
  result_t result_q;

  assign pready = 1'b1;

  msup_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // handshake flow between the two registers
  assign advance  = !out_valid || out_ready;
  assign fire     = item_valid && advance;
  assign in_ready = !item_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.cmd           <= cmd;
      item.now_ms        <= TimeWidth'(now_ms);
      item.drive_level   <= drive_level;
      item.encoder_count <= encoder_count;
      item.force_raw     <= force_raw;
    end
  end

  msup_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_q <= result;
    end
  end

  assign fault_code   = result_q.fault_code;
  assign estop_active = result_q.estop_active;
  assign stop_motor   = result_q.stop_motor;

  // a new stop always comes with the latch set
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && stop_motor) |-> estop_active)
    else $error("stop pulse without latched stop");

  // a fault code is reported exactly while the stop is latched
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((fault_code != ErrNone) == estop_active))
    else $error("fault code and latch state disagree");

  // an empty result register never blocks the input
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // a processed item always shows up as a result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed item produced no result");

endmodule

// ===== hw/rtl/msup_regs.sv =====
// configuration register file behind the apb-style port
module msup_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [msup_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [msup_pkg::CfgDataWidth-1:0] pwdata,
  output logic [msup_pkg::CfgDataWidth-1:0] prdata,
  output msup_pkg::cfg_t                    cfg
);
  import msup_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // register writes on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stall_drive_limit <= StallDriveLimitRst;
      cfg.stall_time_ms     <= StallTimeMsRst;
      cfg.link_timeout_ms   <= LinkTimeoutMsRst;
      cfg.force_limit       <= ForceLimitRst;
    end else if (wr_en) begin
      case (reg_idx)
        RegStallDriveLimit: cfg.stall_drive_limit <= pwdata[14:0];
        RegStallTimeMs:     cfg.stall_time_ms     <= pwdata[15:0];
        RegLinkTimeoutMs:   cfg.link_timeout_ms   <= pwdata[15:0];
        RegForceLimit:      cfg.force_limit       <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      RegStallDriveLimit: prdata = CfgDataWidth'(cfg.stall_drive_limit);
      RegStallTimeMs:     prdata = CfgDataWidth'(cfg.stall_time_ms);
      RegLinkTimeoutMs:   prdata = CfgDataWidth'(cfg.link_timeout_ms);
      RegForceLimit:      prdata = CfgDataWidth'(cfg.force_limit);
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/msup_core.sv =====
// fault evaluation and supervisor state, one item per cycle while fire is high
module msup_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  msup_pkg::item_t   item,
  input  msup_pkg::cfg_t    cfg,
  output msup_pkg::result_t result
);
  import msup_pkg::*;

  // supervisor state
  logic               stall_timing;
  time_t              stall_start_ms;
  logic [15:0]        stall_start_position;
  time_t              last_frame_ms;
  logic               estop_latched;
  logic [1:0]         latched_error;

  logic               stall_timing_next;
  time_t              stall_start_ms_next;
  logic [15:0]        stall_start_position_next;
  time_t              last_frame_ms_next;
  logic               estop_latched_next;
  logic [1:0]         latched_error_next;

  logic [16:0]        drive_mag;
  logic               drive_high;
  logic signed [15:0] enc_delta;
  logic               no_motion;
  time_t              link_gap;
  time_t              stall_elapsed;
  logic               link_fault;
  logic               stall_fault;
  logic               force_fault;
  logic [1:0]         err;
  logic               stop;

  // magnitude of the drive, -32768 maps to 32768
  assign drive_mag  = item.drive_level[15] ? (17'd0 - {1'b1, item.drive_level})
                                           : {1'b0, item.drive_level};
  assign drive_high = drive_mag > {2'b00, cfg.stall_drive_limit};

  // wrapping encoder and time differences
  assign enc_delta     = $signed(item.encoder_count - stall_start_position);
  assign no_motion     = (enc_delta < MotionBand) && (enc_delta > -MotionBand);
  assign link_gap      = item.now_ms - last_frame_ms;
  assign stall_elapsed = item.now_ms - stall_start_ms;

  assign link_fault  = link_gap > TimeWidth'(cfg.link_timeout_ms);
  assign stall_fault = drive_high && stall_timing && no_motion &&
                       (stall_elapsed >= TimeWidth'(cfg.stall_time_ms));
  assign force_fault = item.force_raw > cfg.force_limit;

  // next state and result for the item at hand
  always_comb begin
    stall_timing_next         = stall_timing;
    stall_start_ms_next       = stall_start_ms;
    stall_start_position_next = stall_start_position;
    last_frame_ms_next        = last_frame_ms;
    estop_latched_next        = estop_latched;
    latched_error_next        = latched_error;
    err                       = ErrNone;
    stop                      = 1'b0;
    case (cmd_t'(item.cmd))
      CmdCheck: begin
        if (!estop_latched) begin
          if (link_fault) begin
            err = ErrLink;
          end else begin
            // stall timing only advances when the link is healthy
            if (drive_high) begin
              if (!stall_timing) begin
                stall_timing_next         = 1'b1;
                stall_start_ms_next       = item.now_ms;
                stall_start_position_next = item.encoder_count;
              end else if (!no_motion) begin
                stall_start_ms_next       = item.now_ms;
                stall_start_position_next = item.encoder_count;
              end
            end else begin
              stall_timing_next = 1'b0;
            end
            if (stall_fault) begin
              err = ErrStall;
            end else if (force_fault) begin
              err = ErrForce;
            end
          end
          if (err != ErrNone) begin
            estop_latched_next = 1'b1;
            latched_error_next = err;
            stop               = 1'b1;
          end
        end
      end
      CmdFrame: begin
        last_frame_ms_next = item.now_ms;
      end
      CmdRearm: begin
        stall_timing_next         = 1'b0;
        stall_start_ms_next       = '0;
        stall_start_position_next = '0;
        last_frame_ms_next        = item.now_ms;
        estop_latched_next        = 1'b0;
        latched_error_next        = ErrNone;
      end
      default: ;
    endcase
    result.fault_code   = estop_latched_next ? latched_error_next : ErrNone;
    result.estop_active = estop_latched_next;
    result.stop_motor   = stop;
  end

  // state update when an item is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      stall_timing         <= 1'b0;
      stall_start_ms       <= '0;
      stall_start_position <= '0;
      last_frame_ms        <= '0;
      estop_latched        <= 1'b0;
      latched_error        <= ErrNone;
    end else if (fire) begin
      stall_timing         <= stall_timing_next;
      stall_start_ms       <= stall_start_ms_next;
      stall_start_position <= stall_start_position_next;
      last_frame_ms        <= last_frame_ms_next;
      estop_latched        <= estop_latched_next;
      latched_error        <= latched_error_next;
    end
  end

endmodule

// ===== test/motor_safety_supervisor_top_test.sv =====
// self-checking testbench of the motor safety supervisor top level
module motor_safety_supervisor_top_test;
  import msup_pkg::*;

  // status predictor and result scoreboard
  class estop_tracker;
    logic [14:0]        drive_limit;
    logic [15:0]        stall_ms_limit;
    logic [15:0]        link_ms_limit;
    logic [11:0]        force_lim;
    bit                 timing;
    time_t              stall_t0;
    logic signed [15:0] stall_pos0;
    time_t              frame_t;
    bit                 latched;
    err_t               held_err;
    result_t            expected_status[$];
    int                 failures;

    function new();
      drive_limit    = StallDriveLimitRst;
      stall_ms_limit = StallTimeMsRst;
      link_ms_limit  = LinkTimeoutMsRst;
      force_lim      = ForceLimitRst;
      timing         = 1'b0;
      stall_t0       = '0;
      stall_pos0     = '0;
      frame_t        = '0;
      latched        = 1'b0;
      held_err       = ErrNone;
      failures       = 0;
    endfunction

    function void set_limit(logic [1:0] idx, logic [31:0] value);
      case (idx)
        RegStallDriveLimit: drive_limit = value[14:0];
        RegStallTimeMs:     stall_ms_limit = value[15:0];
        RegLinkTimeoutMs:   link_ms_limit = value[15:0];
        RegForceLimit:      force_lim = value[11:0];
        default: ;
      endcase
    endfunction

    // stall timing; reports a stall once the encoder has sat still long enough
    function bit stall_seen(time_t t, logic signed [15:0] drv, logic signed [15:0] enc);
      int                 mag;
      logic signed [15:0] moved;
      time_t              held_for;
      mag = (drv < 0) ? -int'(drv) : int'(drv);
      if (mag <= int'(drive_limit)) begin
        timing = 1'b0;
        return 1'b0;
      end
      if (!timing) begin
        timing     = 1'b1;
        stall_t0   = t;
        stall_pos0 = enc;
        return 1'b0;
      end
      moved    = enc - stall_pos0;
      held_for = t - stall_t0;
      if (moved < MotionBand && moved > -MotionBand) begin
        return held_for >= stall_ms_limit;
      end
      // motion outside the band restarts the timing here
      stall_t0   = t;
      stall_pos0 = enc;
      return 1'b0;
    endfunction

    // predict the status for one accepted input transfer
    function void note_item(cmd_t c, time_t t, logic signed [15:0] drv,
                            logic signed [15:0] enc, logic [11:0] frc);
      result_t r;
      err_t    fault;
      time_t   since_frame;
      r     = '0;
      fault = ErrNone;
      case (c)
        CmdCheck: begin
          if (!latched) begin
            since_frame = t - frame_t;
            if (since_frame > link_ms_limit) fault = ErrLink;
            else if (stall_seen(t, drv, enc)) fault = ErrStall;
            else if (frc > force_lim) fault = ErrForce;
            if (fault != ErrNone) begin
              latched      = 1'b1;
              held_err     = fault;
              r.stop_motor = 1'b1;
            end
          end
        end
        CmdFrame: begin
          frame_t = t;
        end
        CmdRearm: begin
          timing     = 1'b0;
          stall_t0   = '0;
          stall_pos0 = '0;
          frame_t    = t;
          latched    = 1'b0;
          held_err   = ErrNone;
        end
        default: ;
      endcase
      r.estop_active = latched;
      r.fault_code   = latched ? held_err : ErrNone;
      expected_status.push_back(r);
    endfunction

    function void report(string what);
      failures++;
      if (failures <= 10) $display("mismatch at %0t: %s", $time, what);
    endfunction

    // compare one result transfer against the oldest prediction
    function void check_status(logic [1:0] fc, logic ea, logic sm);
      result_t want;
      if (expected_status.size() == 0) begin
        report($sformatf("unexpected result: fault_code %0d estop_active %0d stop_motor %0d",
                         fc, ea, sm));
        return;
      end
      want = expected_status.pop_front();
      if (fc !== want.fault_code)
        report($sformatf("fault_code: expected %0d, got %0d", want.fault_code, fc));
      if (ea !== want.estop_active)
        report($sformatf("estop_active: expected %0d, got %0d", want.estop_active, ea));
      if (sm !== want.stop_motor)
        report($sformatf("stop_motor: expected %0d, got %0d", want.stop_motor, sm));
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CfgAddrWidth-1:0] paddr;
  logic [CfgDataWidth-1:0] pwdata;
  logic [CfgDataWidth-1:0] prdata;
  logic                    pready;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              cmd;
  logic [31:0]             now_ms;
  logic signed [15:0]      drive_level;
  logic signed [15:0]      encoder_count;
  logic [11:0]             force_raw;
  logic                    out_valid;
  logic                    out_ready;
  logic [1:0]              fault_code;
  logic                    estop_active;
  logic                    stop_motor;

  estop_tracker tracker;
  int           gap_pct = 0;

  motor_safety_supervisor_top DUT (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // known values on every input from the start
  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    cmd           = CmdCheck;
    now_ms        = '0;
    drive_level   = '0;
    encoder_count = '0;
    force_raw     = '0;
    out_ready     = 1'b0;
  end

  // receiver with random stall bursts
  always begin
    @(posedge clk);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_status(fault_code, estop_active, stop_motor);
  end

  // one input transfer, with an optional idle burst ahead of it
  task automatic send_item(input cmd_t c, input time_t t, input logic signed [15:0] drv,
                           input logic signed [15:0] enc, input logic [11:0] frc);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= c;
    now_ms        <= t;
    drive_level   <= drv;
    encoder_count <= enc;
    force_raw     <= frc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_item(c, t, drv, enc, frc);
  endtask

  // back-to-back writes of all four limit registers
  task automatic load_limits(input logic [31:0] drive_v, input logic [31:0] stall_v,
                             input logic [31:0] link_v, input logic [31:0] force_v);
    logic [1:0]  regs [4] = '{RegStallDriveLimit, RegStallTimeMs, RegLinkTimeoutMs,
                              RegForceLimit};
    logic [31:0] vals [4];
    vals = '{drive_v, stall_v, link_v, force_v};
    for (int i = 0; i < 4; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {regs[i], 2'b00};
      pwdata  <= vals[i];
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      tracker.set_limit(regs[i], vals[i]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stop sending and wait for every predicted result
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_limit(int bits);
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = (32'd1 << bits) - 32'd1;
      2, 3: v = $urandom_range(0, 400);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  initial begin : stimulus
    time_t              now_t;
    cmd_t               c;
    logic signed [15:0] drv;
    logic signed [15:0] enc;
    logic signed [15:0] anchor;
    logic [11:0]        frc;
    int                 roll;
    int                 mag;
    int                 lim;
    int                 cap;
    tracker = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    gap_pct = 20;

    // default limits: link timeout, latched answers, force, stall start and restart
    send_item(CmdCheck, 32'd0, 16'sd0, 16'sd0, 12'd0);
    send_item(CmdFrame, 32'd50, 16'sd0, 16'sd0, 12'd0);
    send_item(CmdCheck, 32'd150, 16'sd0, 16'sd0, 12'd3500);
    send_item(CmdCheck, 32'd151, 16'sd0, 16'sd0, 12'd0);
    send_item(CmdCheck, 32'd160, 16'sd0, 16'sd0, 12'd4095);
    send_item(CmdFrame, 32'd200, 16'sd0, 16'sd0, 12'd0);
    send_item(CmdRearm, 32'd200, 16'sd0, 16'sd0, 12'd0);
    send_item(CmdCheck, 32'd201, 16'sd0, 16'sd0, 12'd3501);
    send_item(CmdRearm, 32'd300, 16'sd0, 16'sd0, 12'd0);
    send_item(CmdCheck, 32'd300, 16'sh8000, 16'sh7FFE, 12'd0);
    send_item(CmdCheck, 32'd350, 16'sh7FFF, 16'sh8002, 12'd0);
    send_item(CmdCheck, 32'd360, 16'sh7FFF, 16'sh8003, 12'd0);
    // link fault wins over force while the stall timing runs
    send_item(CmdCheck, 32'd401, 16'sd1000, 16'sh8003, 12'd4095);
    send_item(CmdRearm, 32'd500, 16'sd0, 16'sd0, 12'd0);

    // zero limits: stall beats force, zero drive stops timing
    drain();
    load_limits(32'd0, 32'd0, 32'hFFFF, 32'd0);
    send_item(CmdCheck, 32'd510, 16'sd1, 16'sd0, 12'd1);
    send_item(CmdRearm, 32'd520, 16'sd0, 16'sd0, 12'd0);
    send_item(CmdCheck, 32'd520, 16'sd0, 16'sd0, 12'd0);
    send_item(CmdCheck, 32'd530, 16'sd1, 16'sd10, 12'd0);
    send_item(CmdCheck, 32'd530, -16'sd1, 16'sd14, 12'd4095);
    send_item(CmdRearm, 32'hFFFF_FF00, 16'sd0, 16'sd0, 12'd0);

    // top limits with the tick wrapping during stall timing
    drain();
    load_limits(32'h7FFF, 32'hFFFF, 32'hFFFF, 32'hFFF);
    send_item(CmdCheck, 32'hFFFF_FF00, 16'sh8000, 16'sh8000, 12'd4095);
    send_item(CmdCheck, 32'h0000_FEFE, 16'sh8000, 16'sh8004, 12'd0);
    send_item(CmdCheck, 32'h0000_FEFF, 16'sh8000, 16'sh7FFC, 12'd0);
    send_item(CmdRearm, 32'd0, 16'sd0, 16'sd0, 12'd0);
    send_item(CmdCheck, 32'd10, 16'sh7FFF, 16'sd0, 12'd0);

    // random phases, each under its own limits, the last one without idling
    for (int phase = 0; phase < 8; phase++) begin
      drain();
      gap_pct = (phase == 7) ? 0 : $urandom_range(0, 3) * 8;
      load_limits(pick_limit(15), pick_limit(16), pick_limit(16), pick_limit(12));
      now_t  = $urandom();
      anchor = 16'($urandom());
      send_item(CmdRearm, now_t, 16'sd0, anchor, 12'd0);
      for (int n = 0; n < 118; n++) begin
        // command: re-arm soon after a latch, frames now and then
        roll = $urandom_range(0, 99);
        if (tracker.latched && $urandom_range(0, 2) == 0) c = CmdRearm;
        else if (roll < 3) c = CmdRearm;
        else if (roll < 23) c = CmdFrame;
        else c = CmdCheck;

        // tick: small steps against the link limit, sometimes long gaps or jumps
        roll = $urandom_range(0, 99);
        cap  = tracker.link_ms_limit / 4 + 1;
        if (roll < 85) now_t = now_t + $urandom_range(0, cap);
        else if (roll < 95) now_t = now_t + $urandom_range(0, 70000);
        else now_t = $urandom();

        // drive: mostly above the stall limit, edges of the limit included
        lim  = tracker.drive_limit;
        roll = $urandom_range(0, 99);
        if (roll < 65) mag = $urandom_range(lim + 1, 32768);
        else if (roll < 80) mag = $urandom_range(0, lim);
        else if (roll < 90) mag = lim + $urandom_range(0, 1);
        else mag = -1;
        if (mag < 0) drv = 16'($urandom());
        else if (mag == 32768 || $urandom_range(0, 1) == 1) drv = 16'(-mag);
        else drv = 16'(mag);

        // encoder: near a resting point, at the band edges, or moved away
        roll = $urandom_range(0, 99);
        if (roll < 75) enc = anchor + 16'($urandom_range(0, 8)) - 16'd4;
        else if (roll < 92) enc = anchor + 16'($urandom_range(0, 12)) - 16'd6;
        else begin
          anchor = 16'($urandom());
          enc    = anchor;
        end

        // force: mostly below the limit, at the limit, or anywhere
        roll = $urandom_range(0, 99);
        if (roll < 85) frc = 12'($urandom_range(0, tracker.force_lim));
        else if (roll < 93) frc = tracker.force_lim + 12'($urandom_range(0, 1));
        else frc = 12'($urandom());

        send_item(c, now_t, drv, enc, frc);
      end
    end

    drain();
    if (tracker.failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== motor_safety_supervisor_top.f =====
hw/rtl/msup_pkg.sv
hw/rtl/msup_regs.sv
hw/rtl/msup_core.sv
hw/rtl/motor_safety_supervisor_top.sv
test/motor_safety_supervisor_top_test.sv
